[hdl/tsu_pkg.sv]
// Shared types and constants of the trigonometric series unit.
package tsu_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RAD,
        S_RAD_W,
        S_LOAD,
        S_X2_W,
        S_TERM,
        S_TMUL_W,
        S_TDIV_W,
        S_FIN,
        S_QDIV_W,
        S_OUT
    } t_state;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_DIV0  = 2'd1;
    localparam t_status ST_RANGE = 2'd2;
    localparam t_status ST_SAT   = 2'd3;

    typedef logic [2:0] t_mode;
    localparam t_mode MODE_SIN = 3'd0;
    localparam t_mode MODE_COS = 3'd1;
    localparam t_mode MODE_TAN = 3'd2;
    localparam t_mode MODE_CSC = 3'd3;
    localparam t_mode MODE_SEC = 3'd4;
    localparam t_mode MODE_COT = 3'd5;

    // Datapath widths
    localparam int DIV_W  = 48;   // dividend and quotient
    localparam int DEN_W  = 32;   // divisor
    localparam int MUL_W  = 36;   // multiplier operands
    localparam int PROD_W = 40;   // Q30 product and running sum

    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1685774664;
    localparam logic signed [31:0] DEG_LIMIT   = 32'sd11796480;
    // Degrees Q16 to radians Q30 is mag * 314 * 16384 / 18000 = mag * 157 * 2^11 / 1125;
    // rounded-up reciprocal scaled by 2^34 gives the exact floor for any clamped angle
    localparam int                 RAD_SHIFT   = 34;
    localparam logic [43:0]        RAD_RECIP   = 44'(((64'd157 << 45) / 64'd1125) + 64'd1);
    localparam logic signed [PROD_W-1:0] ONE_Q30 = 40'sd1073741824;

endpackage

[hdl/tsu_mul.sv]
// Two-pass Q30 multiplier sharing one 36 x 21 bit multiplier.
module tsu_mul import tsu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MUL_W-1:0]  i_a,
    input  logic [MUL_W-1:0]  i_b,
    output logic              o_done,
    output logic [PROD_W-1:0] o_res
);

    localparam int HI_W = MUL_W - 15;
    localparam int P_W  = MUL_W + HI_W;

    logic [1:0]       r_phase;
    logic             r_done;
    logic [MUL_W-1:0] r_a;
    logic [MUL_W-1:0] r_b;
    logic [P_W-1:0]   r_ph;
    logic [P_W-1:0]   r_pl;
    logic [HI_W-1:0]  op_b;
    logic [P_W-1:0]   prod;
    logic [P_W:0]     comb_sum;

    // Upper part of b on the first pass, low 15 bits on the second
    assign op_b = (r_phase == 2'd1) ? r_b[MUL_W-1:15] : HI_W'(r_b[14:0]);
    assign prod = P_W'(r_a) * P_W'(op_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                2'd0: if (i_start) r_phase <= 2'd1;
                2'd1: r_phase <= 2'd2;
                2'd2: begin
                    r_phase <= 2'd0;
                    r_done  <= 1'b1;
                end
                default: r_phase <= 2'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == 2'd0 && i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_phase == 2'd1) r_ph <= prod;
        if (r_phase == 2'd2) r_pl <= prod;
    end

    assign comb_sum = (P_W + 1)'(r_ph) + (P_W + 1)'(r_pl >> 15);
    assign o_res    = comb_sum[PROD_W+14:15];
    assign o_done   = r_done;

endmodule

[hdl/tsu_div.sv]
// Restoring divider, one quotient bit per cycle.
module tsu_div import tsu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIV_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign rem_sh = {r_rem, r_q[DIV_W-1]};
    assign diff   = rem_sh - {1'b0, r_den};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_q   <= {r_q[DIV_W-2:0], ge};
        end else if (i_start) begin
            r_rem <= '0;
            r_q   <= i_num;
            r_den <= i_den;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

[hdl/trig_series_unit_core.sv]
// Trigonometric series unit: sequencer, shared multiplier and divider, output register.
// Two series passes, each term divided by the 48-step divider; the quotient functions
//   add a final division.
// Throughput: one item at a time; the input stalls from acceptance until the result
//   enters the output register.
// Reset: synchronous, active low; clears the sequencer, the units and output valid.
module trig_series_unit_core import tsu_pkg::*; #(
    parameter int SERIES_TERMS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_mode,
    input  logic signed [31:0] i_angle_deg,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [31:0] o_value,
    output logic [1:0]  o_status
);

    localparam int KW = $clog2(2 * SERIES_TERMS);
    localparam int DW = 2 * KW + 2;

    t_state r_state, n_state;

    // Item context
    t_mode       r_mode, n_mode;
    logic        r_rng, n_rng;
    logic        r_aneg, n_aneg;
    logic [23:0] r_mag, n_mag;
    logic [45:0] r_rlo, n_rlo;
    logic [31:0] r_rmag, n_rmag;

    // Series state
    logic                     r_pass, n_pass;
    logic                     r_xneg, n_xneg;
    logic [KW-1:0]            r_k, n_k;
    logic [MUL_W-1:0]         r_x2, n_x2;
    logic [MUL_W-1:0]         r_term, n_term;
    logic signed [PROD_W-1:0] r_sum, n_sum;
    logic signed [PROD_W-1:0] r_s, n_s;
    logic signed [PROD_W-1:0] r_c, n_c;

    // Result
    logic                     r_qneg, n_qneg;
    logic signed [31:0]       r_res_val, n_res_val;
    t_status                  r_res_st, n_res_st;
    logic                     r_out_valid, n_out_valid;
    logic signed [31:0]       r_value, n_value;
    t_status                  r_status, n_status;

    // Shared units
    logic              mul_start, mul_done;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_res;
    logic              div_start, div_busy, div_done;
    logic [DIV_W-1:0]  div_num, div_quo;
    logic [DEN_W-1:0]  div_den;

    // Helpers
    logic                     in_xfer;
    logic [21:0]              rad_op;
    logic [45:0]              rad_prod;
    logic [67:0]              rad_full;
    logic signed [33:0]       rad, xval;
    logic [32:0]              ax;
    logic [DW-1:0]            dfac;
    logic signed [PROD_W-1:0] term_s, sum_upd, sum_fin;
    logic signed [PROD_W-1:0] q_num, q_den, s_sel;
    logic [PROD_W-1:0]        num_abs, den_abs, s_abs, s_scl;
    logic                     out_free;

    tsu_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    tsu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Radian conversion by reciprocal: low half of the constant first, high half next
    assign rad_op   = (r_state == S_RAD) ? RAD_RECIP[21:0] : RAD_RECIP[43:22];
    assign rad_prod = 46'(r_mag) * 46'(rad_op);
    assign rad_full = (68'(rad_prod) << 22) + 68'(r_rlo);

    // Radians with sign; second pass works on the complementary angle
    assign rad  = r_aneg ? -34'(r_rmag) : 34'(r_rmag);
    assign xval = r_pass ? (HALF_PI_Q30 - rad) : rad;
    assign ax   = xval[33] ? 33'(-xval) : 33'(xval);

    // Series divisor (2k)(2k+1)
    assign dfac = DW'({r_k, 1'b0}) * DW'({r_k, 1'b1});

    assign term_s  = PROD_W'(div_quo[MUL_W-1:0]);
    assign sum_upd = r_k[0] ? (r_sum - term_s) : (r_sum + term_s);
    assign sum_fin = r_xneg ? -sum_upd : sum_upd;

    // Quotient operands by function
    always_comb begin
        case (r_mode)
            MODE_TAN: begin q_num = r_s;     q_den = r_c; end
            MODE_CSC: begin q_num = ONE_Q30; q_den = r_s; end
            MODE_SEC: begin q_num = ONE_Q30; q_den = r_c; end
            MODE_COT: begin q_num = r_c;     q_den = r_s; end
            default:  begin q_num = r_s;     q_den = r_c; end
        endcase
    end
    assign num_abs = q_num[PROD_W-1] ? PROD_W'(-q_num) : PROD_W'(q_num);
    assign den_abs = q_den[PROD_W-1] ? PROD_W'(-q_den) : PROD_W'(q_den);

    // Sine or cosine scaled to Q16.16, truncated toward zero
    assign s_sel = (r_mode == MODE_COS) ? r_c : r_s;
    assign s_abs = s_sel[PROD_W-1] ? PROD_W'(-s_sel) : PROD_W'(s_sel);
    assign s_scl = s_abs >> 14;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_rng     <= n_rng;
        r_aneg    <= n_aneg;
        r_mag     <= n_mag;
        r_rlo     <= n_rlo;
        r_rmag    <= n_rmag;
        r_pass    <= n_pass;
        r_xneg    <= n_xneg;
        r_k       <= n_k;
        r_x2      <= n_x2;
        r_term    <= n_term;
        r_sum     <= n_sum;
        r_s       <= n_s;
        r_c       <= n_c;
        r_qneg    <= n_qneg;
        r_res_val <= n_res_val;
        r_res_st  <= n_res_st;
        r_value   <= n_value;
        r_status  <= n_status;
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_rng       = r_rng;
        n_aneg      = r_aneg;
        n_mag       = r_mag;
        n_rlo       = r_rlo;
        n_rmag      = r_rmag;
        n_pass      = r_pass;
        n_xneg      = r_xneg;
        n_k         = r_k;
        n_x2        = r_x2;
        n_term      = r_term;
        n_sum       = r_sum;
        n_s         = r_s;
        n_c         = r_c;
        n_qneg      = r_qneg;
        n_res_val   = r_res_val;
        n_res_st    = r_res_st;
        n_value     = r_value;
        n_status    = r_status;
        n_out_valid = r_out_valid && i_out_stall;
        mul_start   = 1'b0;
        mul_a       = MUL_W'(ax);
        mul_b       = MUL_W'(ax);
        div_start   = 1'b0;
        div_num     = DIV_W'(mul_res);
        div_den     = DEN_W'(dfac);

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    // Clamp the angle to +-180 degrees and keep its magnitude
                    n_mode = i_mode;
                    if (i_angle_deg > DEG_LIMIT) begin
                        n_rng  = 1'b1;
                        n_aneg = 1'b0;
                        n_mag  = DEG_LIMIT[23:0];
                    end else if (i_angle_deg < -DEG_LIMIT) begin
                        n_rng  = 1'b1;
                        n_aneg = 1'b1;
                        n_mag  = DEG_LIMIT[23:0];
                    end else begin
                        n_rng  = 1'b0;
                        n_aneg = i_angle_deg[31];
                        n_mag  = i_angle_deg[31] ? 24'(-i_angle_deg) : i_angle_deg[23:0];
                    end
                    n_state = S_RAD;
                end
            end
            S_RAD: begin
                // Hold the low partial product of the radian scaling
                n_rlo   = rad_prod;
                n_state = S_RAD_W;
            end
            S_RAD_W: begin
                n_rmag  = rad_full[RAD_SHIFT+31:RAD_SHIFT];
                n_pass  = 1'b0;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                // Seed the series with |x| and start x squared
                mul_start = 1'b1;
                n_xneg    = xval[33];
                n_term    = MUL_W'(ax);
                n_sum     = PROD_W'(ax);
                n_k       = KW'(1);
                n_state   = S_X2_W;
            end
            S_X2_W: begin
                if (mul_done) begin
                    n_x2    = mul_res[MUL_W-1:0];
                    n_state = S_TERM;
                end
            end
            S_TERM: begin
                mul_start = 1'b1;
                mul_a     = r_term;
                mul_b     = r_x2;
                n_state   = S_TMUL_W;
            end
            S_TMUL_W: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    div_num   = DIV_W'(mul_res);
                    div_den   = DEN_W'(dfac);
                    n_state   = S_TDIV_W;
                end
            end
            S_TDIV_W: begin
                if (div_done) begin
                    n_term = div_quo[MUL_W-1:0];
                    n_sum  = sum_upd;
                    if (r_k == KW'(2 * SERIES_TERMS - 1)) begin
                        if (!r_pass) begin
                            n_s     = sum_fin;
                            n_pass  = 1'b1;
                            n_state = S_LOAD;
                        end else begin
                            n_c     = sum_fin;
                            n_state = S_FIN;
                        end
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_TERM;
                    end
                end
            end
            S_FIN: begin
                case (r_mode)
                    MODE_SIN, MODE_COS: begin
                        n_res_val = s_sel[PROD_W-1] ? -32'(s_scl) : 32'(s_scl);
                        n_res_st  = r_rng ? ST_RANGE : ST_OK;
                        n_state   = S_OUT;
                    end
                    MODE_TAN, MODE_CSC, MODE_SEC, MODE_COT: begin
                        if (q_den == '0) begin
                            n_res_val = q_num[PROD_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                            n_res_st  = ST_DIV0;
                            n_state   = S_OUT;
                        end else begin
                            div_start = 1'b1;
                            div_num   = DIV_W'(num_abs) << 16;
                            div_den   = den_abs[DEN_W-1:0];
                            n_qneg    = q_num[PROD_W-1] ^ q_den[PROD_W-1];
                            n_state   = S_QDIV_W;
                        end
                    end
                    default: begin
                        n_res_val = '0;
                        n_res_st  = ST_OK;
                        n_state   = S_OUT;
                    end
                endcase
            end
            S_QDIV_W: begin
                if (div_done) begin
                    // Saturate to the signed 32-bit range
                    if (!r_qneg && div_quo > DIV_W'(32'h7FFF_FFFF)) begin
                        n_res_val = 32'sh7FFF_FFFF;
                        n_res_st  = ST_SAT;
                    end else if (r_qneg && div_quo > DIV_W'(32'h8000_0000)) begin
                        n_res_val = 32'sh8000_0000;
                        n_res_st  = ST_SAT;
                    end else begin
                        n_res_val = r_qneg ? -div_quo[31:0] : div_quo[31:0];
                        n_res_st  = r_rng ? ST_RANGE : ST_OK;
                    end
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // Hold until the output register is free, then hand over
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_value     = r_res_val;
                    n_status    = r_res_st;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_status    = r_status;

    // The two units never start together
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_start && div_start))
        else $error("multiplier and divider started together");

    // The divider is never restarted while busy
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // Handing over a result always raises output valid
    a_hand_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("result not handed to output register");

    // An accepted item always moves the sequencer to S_RAD
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_RAD))
        else $error("accepted item did not start the sequence");

endmodule
